/* src/pra_pkg.sv */
`default_nettype none
package pra_pkg;

    typedef logic [2:0] page_st_t;
    typedef logic [2:0] status_t;

    // Page map codes
    localparam page_st_t PG_FREE     = 3'd0;
    localparam page_st_t PG_USED     = 3'd1;
    localparam page_st_t PG_START    = 3'd2;
    localparam page_st_t PG_END      = 3'd3;
    localparam page_st_t PG_SINGLE   = 3'd4;
    localparam page_st_t PG_UNUSABLE = 3'd7;

    // Result status codes
    localparam status_t RES_OK        = 3'd0;
    localparam status_t RES_EXHAUSTED = 3'd1;
    localparam status_t RES_FREE_PAGE = 3'd2;
    localparam status_t RES_BAD_MARK  = 3'd3;
    localparam status_t RES_RAN_OFF   = 3'd4;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_RESERVED_FIRST = 1'b0;
    localparam logic CFG_RESERVED_COUNT = 1'b1;

    localparam int PAGE_W  = 12;
    localparam int COUNT_W = 13;

endpackage
`default_nettype wire

/* src/pra_map.sv */
`default_nettype none
module pra_map
    import pra_pkg::*;
#(
    parameter int NUM_PAGES = 4096
) (
    input  wire logic                            aclk,
    input  wire logic [$clog2(NUM_PAGES)-1:0]    rd_addr,
    input  wire logic                            wr_en,
    input  wire logic [$clog2(NUM_PAGES)-1:0]    wr_addr,
    input  wire page_st_t                        wr_data,
    input  wire logic [PAGE_W-1:0]               reserved_first,
    input  wire logic [COUNT_W-1:0]              reserved_count,
    output page_st_t                             rd_state
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int XW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

    page_st_t         mem [NUM_PAGES];
    page_st_t         rd_data_reg;
    logic             res_reg;
    logic             in_res;
    logic [XW-1:0]    addr_x;
    logic [XW-1:0]    first_x;
    logic [XW-1:0]    count_x;

    // Reserved window is clipped at the last page and never wraps
    always_comb begin
        addr_x  = XW'(rd_addr);
        first_x = XW'(reserved_first);
        count_x = XW'(reserved_count);
        in_res  = (addr_x >= first_x) && ((addr_x - first_x) < count_x);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        res_reg     <= in_res;
    end

    assign rd_state = res_reg ? PG_UNUSABLE : rd_data_reg;

endmodule
`default_nettype wire

/* src/page_run_allocator.sv */
// Allocate: setup (accept, issue), then a scan of the map (at most two full
//   passes), then the run is marked page by page from its last page back, then finish.
// Free: setup (accept, issue), then a walk along the run freeing page by page, then finish.
// One item at a time; the page map read/write port sets the pace (one page a cycle).
// Reset: synchronous active low; afterwards a clearing pass sets every page free
//   before the first item is accepted.
`default_nettype none
module page_run_allocator
    import pra_pkg::*;
#(
    parameter int NUM_PAGES = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_opcode,
    input  wire logic [COUNT_W-1:0]   s_page_count,
    input  wire logic [PAGE_W-1:0]    s_page_index,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output status_t                   m_status,
    output logic [PAGE_W-1:0]         m_first_page,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [COUNT_W-1:0]   cfg_data
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam int XW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
    localparam logic [AW-1:0] LAST_PAGE   = AW'(NUM_PAGES - 1);
    localparam logic [XW-1:0] NUM_PAGES_X = XW'(NUM_PAGES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_WALK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       scan_p_reg, scan_p_next;
    logic [AW:0]         run_reg, run_next;
    logic [AW-1:0]       first_reg, first_next;
    logic [AW-1:0]       end_reg, end_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic                wrapped_reg, wrapped_next;
    logic                head_reg, head_next;
    logic                op_reg, op_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    status_t             res_status_reg, res_status_next;
    logic [AW-1:0]       res_first_reg, res_first_next;
    logic [PAGE_W-1:0]   rf_reg;
    logic [COUNT_W-1:0]  rc_reg;
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [PAGE_W-1:0]   m_first_reg;

    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    page_st_t            wr_data;
    page_st_t            page_st;
    logic [XW-1:0]       count_x;
    logic [XW-1:0]       run_inc_x;
    logic [XW-1:0]       index_x;
    logic                accept;
    logic                out_free;

    pra_map #(
        .NUM_PAGES (NUM_PAGES)
    ) u_map (
        .aclk           (aclk),
        .rd_addr        (rd_addr),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .reserved_first (rf_reg),
        .reserved_count (rc_reg),
        .rd_state       (page_st)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign count_x   = XW'(count_reg);
    assign run_inc_x = XW'(run_reg) + XW'(1);
    assign index_x   = XW'(s_page_index);

    always_comb begin
        state_next      = state_reg;
        scan_p_next     = scan_p_reg;
        run_next        = run_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        ptr_next        = ptr_reg;
        wrapped_next    = wrapped_reg;
        head_next       = head_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_first_next  = res_first_reg;
        rd_addr         = scan_p_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_p_reg;
        wr_data         = PG_FREE;

        unique case (state_reg)
            S_CLEAR: begin
                wr_en = 1'b1;
                if (scan_p_reg == LAST_PAGE) begin
                    state_next = S_IDLE;
                end else begin
                    scan_p_next = scan_p_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    op_next         = s_opcode;
                    count_next      = s_page_count;
                    run_next        = '0;
                    wrapped_next    = 1'b0;
                    head_next       = 1'b1;
                    res_first_next  = '0;
                    if (s_opcode == OP_ALLOC) begin
                        scan_p_next = ptr_reg;
                        if (s_page_count == '0) begin
                            res_status_next = RES_EXHAUSTED;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_ISSUE;
                        end
                    end else begin
                        scan_p_next = index_x[AW-1:0];
                        if (index_x >= NUM_PAGES_X) begin
                            res_status_next = RES_RAN_OFF;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_ISSUE;
                        end
                    end
                end
            end
            S_ISSUE: begin
                state_next = (op_reg == OP_ALLOC) ? S_SCAN : S_WALK;
            end
            S_SCAN: begin
                if (page_st == PG_FREE && run_inc_x == count_x) begin
                    // Run complete: mark it back from its last page
                    end_next   = scan_p_reg;
                    if (run_reg == '0) begin
                        first_next = scan_p_reg;
                    end
                    state_next = S_MARK;
                end else if (scan_p_reg == LAST_PAGE) begin
                    // Runs never span the wrap
                    if (wrapped_reg) begin
                        ptr_next        = '0;
                        res_status_next = RES_EXHAUSTED;
                        state_next      = S_DONE;
                    end else begin
                        wrapped_next = 1'b1;
                        run_next     = '0;
                        scan_p_next  = '0;
                        rd_addr      = '0;
                    end
                end else begin
                    if (page_st == PG_FREE) begin
                        run_next = run_reg + (AW+1)'(1);
                        if (run_reg == '0) begin
                            first_next = scan_p_reg;
                        end
                    end else begin
                        run_next = '0;
                    end
                    scan_p_next = scan_p_reg + AW'(1);
                    rd_addr     = scan_p_reg + AW'(1);
                end
            end
            S_MARK: begin
                wr_en = 1'b1;
                if (first_reg == end_reg) begin
                    wr_data = PG_SINGLE;
                end else if (scan_p_reg == end_reg) begin
                    wr_data = PG_END;
                end else if (scan_p_reg == first_reg) begin
                    wr_data = PG_START;
                end else begin
                    wr_data = PG_USED;
                end
                if (scan_p_reg == first_reg) begin
                    ptr_next        = (end_reg == LAST_PAGE) ? '0 : end_reg + AW'(1);
                    res_status_next = RES_OK;
                    res_first_next  = first_reg;
                    state_next      = S_DONE;
                end else begin
                    scan_p_next = scan_p_reg - AW'(1);
                end
            end
            S_WALK: begin
                case (page_st) inside
                    PG_FREE: begin
                        res_status_next = RES_FREE_PAGE;
                        state_next      = S_DONE;
                    end
                    PG_SINGLE, PG_END: begin
                        if (head_reg == (page_st == PG_SINGLE)) begin
                            wr_en           = 1'b1;
                            res_status_next = RES_OK;
                        end else begin
                            res_status_next = RES_BAD_MARK;
                        end
                        state_next = S_DONE;
                    end
                    PG_START, PG_USED: begin
                        if (page_st == PG_START && !head_reg) begin
                            res_status_next = RES_BAD_MARK;
                            state_next      = S_DONE;
                        end else begin
                            // Free this page and advance
                            wr_en     = 1'b1;
                            head_next = 1'b0;
                            if (scan_p_reg == LAST_PAGE) begin
                                res_status_next = RES_RAN_OFF;
                                state_next      = S_DONE;
                            end else begin
                                scan_p_next = scan_p_reg + AW'(1);
                                rd_addr     = scan_p_reg + AW'(1);
                            end
                        end
                    end
                    default: begin
                        res_status_next = RES_BAD_MARK;
                        state_next      = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            scan_p_reg  <= '0;
            ptr_reg     <= '0;
            rf_reg      <= '0;
            rc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            scan_p_reg <= scan_p_next;
            ptr_reg    <= ptr_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RESERVED_FIRST: rf_reg <= cfg_data[PAGE_W-1:0];
                    CFG_RESERVED_COUNT: rc_reg <= cfg_data;
                    default:            rc_reg <= rc_reg;
                endcase
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        run_reg        <= run_next;
        first_reg      <= first_next;
        end_reg        <= end_next;
        wrapped_reg    <= wrapped_next;
        head_reg       <= head_next;
        op_reg         <= op_next;
        count_reg      <= count_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_first_reg  <= PAGE_W'(res_first_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_first_page = m_first_reg;

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("item accepted during clearing pass");

    a_mark_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MARK) |-> (scan_p_reg >= first_reg && scan_p_reg <= end_reg))
        else $error("mark pointer left the run");

    a_run_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (XW'(run_reg) < count_x))
        else $error("run length reached count without a fit");

    a_ptr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= LAST_PAGE)
        else $error("next-fit pointer out of range");

    a_done_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_valid && state_reg == S_IDLE))
        else $error("finished item not delivered");
`endif

endmodule
`default_nettype wire

/* dv/page_run_allocator_tb.sv */
module page_run_allocator_tb;
    import pra_pkg::*;

    localparam int NUM_PAGES   = 4096;
    localparam int MAX_GAP     = 17;
    // slowest item: two full scans plus marking a whole map, plus stalls
    localparam int QUIET_LIMIT = 8 * (3 * NUM_PAGES + 64 + 2 * MAX_GAP);
    localparam int SETTLE      = 256;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        status_t             status;
        logic [PAGE_W-1:0]   first_page;
    } outcome_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic                 s_opcode     = OP_ALLOC;
    logic [COUNT_W-1:0]   s_page_count = '0;
    logic [PAGE_W-1:0]    s_page_index = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    status_t              m_status;
    logic [PAGE_W-1:0]    m_first_page;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index    = CFG_RESERVED_FIRST;
    logic [COUNT_W-1:0]   cfg_data     = '0;

    // allocator state as the testbench sees it
    page_st_t             page_marks [NUM_PAGES];
    int unsigned          fit_ptr;
    int unsigned          win_first;
    int unsigned          win_count;

    outcome_t             pending_results [$];
    logic [PAGE_W-1:0]    live_starts [$];
    bit                   gaps_on      = 1'b1;
    int                   mismatches   = 0;
    int unsigned          quiet_cycles = 0;
    int                   n_requests   = 0;
    int                   n_placed     = 0;
    int                   n_exhausted  = 0;
    int                   n_freed      = 0;
    int                   n_refused    = 0;
    int                   n_windows    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    page_run_allocator #(
        .NUM_PAGES(NUM_PAGES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_opcode(s_opcode),
        .s_page_count(s_page_count),
        .s_page_index(s_page_index),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_first_page(m_first_page),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic page_st_t page_view(input int unsigned p);
        if (p >= NUM_PAGES) return PG_UNUSABLE;
        if (p >= win_first && (p - win_first) < win_count) return PG_UNUSABLE;
        return page_marks[p];
    endfunction

    // next-fit search; a run never crosses the last page
    function automatic outcome_t place_run(input int unsigned count);
        outcome_t    res;
        int unsigned p;
        int unsigned run_len;
        int unsigned head;
        int unsigned i;
        bit          wrapped;
        bit          done;
        res.status     = RES_EXHAUSTED;
        res.first_page = '0;
        if (count == 0) return res;
        p       = fit_ptr;
        run_len = 0;
        head    = 0;
        wrapped = 1'b0;
        done    = 1'b0;
        while (!done) begin
            if (p >= NUM_PAGES) begin
                p       = 0;
                run_len = 0;
                if (wrapped) begin
                    fit_ptr = 0;
                    done    = 1'b1;
                end
                wrapped = 1'b1;
            end
            if (!done) begin
                if (page_view(p) == PG_FREE) begin
                    if (run_len == 0) head = p;
                    run_len++;
                    if (run_len == count) begin
                        if (count == 1) begin
                            page_marks[head] = PG_SINGLE;
                        end else begin
                            for (i = 0; i < count; i++) begin
                                if (i == 0) page_marks[head + i] = PG_START;
                                else if (i == count - 1) page_marks[head + i] = PG_END;
                                else page_marks[head + i] = PG_USED;
                            end
                        end
                        fit_ptr        = (head + count >= NUM_PAGES) ? 0 : head + count;
                        res.status     = RES_OK;
                        res.first_page = PAGE_W'(head);
                        done           = 1'b1;
                    end
                end else begin
                    run_len = 0;
                end
                p++;
            end
        end
        return res;
    endfunction

    // walk a run from its start mark to its end mark, freeing as it goes
    function automatic outcome_t release_run(input int unsigned start);
        outcome_t    res;
        int unsigned p;
        page_st_t    mark;
        bit          head_page;
        bit          done;
        res.status     = RES_OK;
        res.first_page = '0;
        p         = start;
        head_page = 1'b1;
        done      = 1'b0;
        while (!done) begin
            if (p >= NUM_PAGES) begin
                res.status = RES_RAN_OFF;
                done       = 1'b1;
            end else begin
                mark = page_view(p);
                case (mark) inside
                    PG_FREE: begin
                        res.status = RES_FREE_PAGE;
                        done       = 1'b1;
                    end
                    PG_SINGLE, PG_START: begin
                        if (!head_page) begin
                            res.status = RES_BAD_MARK;
                            done       = 1'b1;
                        end else begin
                            page_marks[p] = PG_FREE;
                            if (mark == PG_SINGLE) done = 1'b1;
                        end
                    end
                    PG_END: begin
                        if (head_page) begin
                            res.status = RES_BAD_MARK;
                        end else begin
                            page_marks[p] = PG_FREE;
                        end
                        done = 1'b1;
                    end
                    PG_USED: begin
                        page_marks[p] = PG_FREE;
                    end
                    default: begin
                        res.status = RES_BAD_MARK;
                        done       = 1'b1;
                    end
                endcase
                p++;
                head_page = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic send_request(input logic op, input logic [COUNT_W-1:0] count,
                                input logic [PAGE_W-1:0] index);
        outcome_t res;
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_page_count <= count;
        s_page_index <= index;
        do @(posedge aclk); while (!s_ready);
        n_requests++;
        if (op == OP_ALLOC) begin
            res = place_run(count);
            if (res.status == RES_OK) begin
                n_placed++;
                live_starts.push_back(res.first_page);
            end else begin
                n_exhausted++;
            end
        end else begin
            res = release_run(index);
            if (res.status == RES_OK) n_freed++;
            else n_refused++;
        end
        pending_results.push_back(res);
    endtask

    task automatic alloc_pages(input logic [COUNT_W-1:0] count);
        send_request(OP_ALLOC, count, PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
    endtask

    task automatic free_run(input logic [PAGE_W-1:0] index);
        send_request(OP_FREE, COUNT_W'($urandom_range(0, 8191)), index);
    endtask

    // drop valid and hold off until every result is back
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [COUNT_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_RESERVED_FIRST) win_first = 32'(value[PAGE_W-1:0]);
        else win_count = 32'(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_window(input int unsigned first, input int unsigned count);
        wait_idle();
        write_reg(CFG_RESERVED_FIRST, COUNT_W'(first));
        write_reg(CFG_RESERVED_COUNT, COUNT_W'(count));
        n_windows++;
    endtask

    task automatic test_alloc_basics();
        alloc_pages(1);
        alloc_pages(3);
        alloc_pages(0);
        // larger than the map: scans on to the end, then the whole map, pointer back to page 0
        alloc_pages(8191);
        alloc_pages(2);
    endtask

    task automatic test_free_walks();
        free_run(0);
        free_run(0);
        free_run(3);
        free_run(2);
        free_run(1);
        free_run(4);
    endtask

    task automatic test_wrap_and_full();
        alloc_pages(COUNT_W'(NUM_PAGES));
        free_run(0);
        alloc_pages(COUNT_W'(NUM_PAGES - 1));
        alloc_pages(1);
        alloc_pages(1);
        free_run(PAGE_W'(NUM_PAGES - 1));
        free_run(0);
    endtask

    task automatic test_reserved_window();
        set_window(100, 8);
        alloc_pages(150);
        free_run(108);
        alloc_pages(10);
        // hide a page inside the live run, then walk into it
        set_window(260, 1);
        free_run(258);
        set_window(0, 0);
        free_run(260);
        // window runs past the map: only the last page is hidden
        set_window(NUM_PAGES - 1, NUM_PAGES);
        alloc_pages(3827);
        alloc_pages(1);
        free_run(268);
        free_run(0);
        set_window(0, NUM_PAGES);
        alloc_pages(1);
        free_run(PAGE_W'(NUM_PAGES - 1));
        set_window(0, 0);
    endtask

    task automatic run_mixed_traffic(input int unsigned n);
        int unsigned        j;
        int unsigned        pick;
        int unsigned        sel;
        int unsigned        k;
        logic [PAGE_W-1:0]  start;
        logic [COUNT_W-1:0] count;
        for (j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            if (live_starts.size() > 48) pick = 60;
            if (pick < 50) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) count = COUNT_W'($urandom_range(1, 8));
                else if (sel < 92) count = COUNT_W'($urandom_range(9, 64));
                else if (sel < 98) count = COUNT_W'($urandom_range(65, 512));
                else count = COUNT_W'($urandom_range(513, NUM_PAGES));
                alloc_pages(count);
            end else if (pick < 90 && live_starts.size() != 0) begin
                k     = $urandom_range(0, live_starts.size() - 1);
                start = live_starts[k];
                live_starts.delete(k);
                free_run(start);
            end else begin
                case ($urandom_range(0, 3))
                    0: free_run(PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
                    1: begin
                        // start a walk inside a run
                        if (live_starts.size() != 0) begin
                            start = live_starts[$urandom_range(0, live_starts.size() - 1)];
                            free_run(start + PAGE_W'(1));
                        end else begin
                            free_run(PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
                        end
                    end
                    2: alloc_pages(0);
                    default: alloc_pages(COUNT_W'($urandom_range(0, 8191)));
                endcase
            end
        end
    endtask

    task automatic test_random_traffic();
        live_starts.delete();
        set_window(0, 0);
        run_mixed_traffic(110);
        set_window($urandom_range(0, NUM_PAGES - 1), $urandom_range(1, 300));
        run_mixed_traffic(110);
        set_window(3900, NUM_PAGES);
        run_mixed_traffic(110);
    endtask

    task automatic test_back_to_back();
        set_window($urandom_range(0, NUM_PAGES - 1), $urandom_range(0, 64));
        gaps_on = 1'b0;
        run_mixed_traffic(120);
    endtask

    always begin
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result status %0d page %0d with no request open",
                                          m_status, m_first_page));
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                if (m_first_page !== want.first_page)
                    report_mismatch($sformatf("first_page %0d, want %0d",
                                              m_first_page, want.first_page));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", quiet_cycles);
            $display("page_run_allocator_tb failed");
            $finish;
        end
    end

    initial begin
        foreach (page_marks[i]) page_marks[i] = PG_FREE;
        fit_ptr   = 0;
        win_first = 0;
        win_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_alloc_basics();
        test_free_walks();
        test_wrap_and_full();
        test_reserved_window();
        test_random_traffic();
        test_back_to_back();

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        $display("%0d requests: %0d runs placed, %0d exhausted, %0d frees done, %0d refused",
                 n_requests, n_placed, n_exhausted, n_freed, n_refused);
        $display("%0d reserved window settings, among them none, whole map and last page only",
                 n_windows);
        if (mismatches == 0)
            $display("page_run_allocator_tb passed");
        else
            $display("page_run_allocator_tb failed");
        $finish;
    end

endmodule

/* sim.f */
src/pra_pkg.sv
src/pra_map.sv
src/page_run_allocator.sv
dv/page_run_allocator_tb.sv
